// ===== rtl/tscd_pkg.sv =====
// Package for the token stop-condition detector.
// Field widths, item and register codes, compare-request and hit types.
// No dependencies.
package tscd_pkg;

	localparam int TOKEN_W    = 18;
	localparam int REQ_W      = 3;
	localparam int SLOT_W     = 3;
	localparam int POS_W      = 4;
	localparam int LEN_W      = 5;
	localparam int COUNT_W    = 4;
	localparam int MINTOK_W   = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int S_TDATA_W  = 32;
	localparam int S_TUSER_W  = 3;
	localparam int M_TDATA_W  = 8;
	localparam int REASON_W   = 2;

	// item kinds
	localparam logic [REQ_W-1:0] REQ_TOKEN    = 3'd0;
	localparam logic [REQ_W-1:0] REQ_EOS_SET  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_STOP_SET = 3'd2;
	localparam logic [REQ_W-1:0] REQ_SEQ_ELEM = 3'd3;
	localparam logic [REQ_W-1:0] REQ_SEQ_LEN  = 3'd4;
	localparam logic [REQ_W-1:0] REQ_BEGIN    = 3'd5;

	// stop reasons
	localparam logic [REASON_W-1:0] RSN_NONE = 2'd0;
	localparam logic [REASON_W-1:0] RSN_EOS  = 2'd1;
	localparam logic [REASON_W-1:0] RSN_STOP = 2'd2;
	localparam logic [REASON_W-1:0] RSN_SEQ  = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIN_TOK    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EOS_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SEQ_COUNT  = 2'd3;

	typedef enum logic [1:0] {
		KIND_EOS  = 2'd0,
		KIND_STOP = 2'd1,
		KIND_SEQ  = 2'd2
	} cmp_kind_t;

	typedef struct packed {
		logic      valid;
		cmp_kind_t kind;
		logic      first;   // first element of a sequence walk
		logic      last;    // last element of a sequence walk
	} cmp_req_t;

	typedef struct packed {
		logic eos;
		logic stop;
		logic seq;
	} hit_t;

endpackage

// ===== rtl/token_stop_condition_detector_unit.sv =====
// Token stop-condition detector, top level: stream ports, config registers,
// table and history RAMs, item sequencer and output register.
// Depends on tscd_pkg, tscd_ram, tscd_walk, tscd_match.
//
// One result item per input item. Load and begin items, and a token before
// the minimum count is met, pass through the exec and finish states before
// s_tready is high again. A checked token also passes through the walk
// state, which covers every enabled stop sequence that fits in the history:
// a single comparator walks the eos table, the stop table and each sequence
// against the history, one RAM read a cycle. The history is a circular
// buffer of SEQ_LEN tokens. s_tready is high only between items; a finished
// result waits in the output register while the next item is taken, and a
// result stalls the block only if the previous one is still unread when the
// next finishes.
module token_stop_condition_detector_unit #(
	parameter int EOS_MAX  = 8,
	parameter int STOP_MAX = 8,
	parameter int SEQ_MAX  = 8,
	parameter int SEQ_LEN  = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// token[17:0], slot[20:18], position[24:21], length[29:25], zero[31:30]
	input  logic [tscd_pkg::S_TDATA_W-1:0]    s_tdata,
	// req_type[2:0]
	input  logic [tscd_pkg::S_TUSER_W-1:0]    s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// done_res[0], reason[2:1], keep_token[3], zero[7:4]
	output logic [tscd_pkg::M_TDATA_W-1:0]    m_tdata,
	input  logic                              cfg_we,
	input  logic [tscd_pkg::CFG_IDX_W-1:0]    cfg_addr,
	input  logic [tscd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import tscd_pkg::*;

	localparam int EN_W = $clog2(EOS_MAX + 1);
	localparam int EA_W = (EOS_MAX > 1) ? $clog2(EOS_MAX) : 1;
	localparam int TN_W = $clog2(STOP_MAX + 1);
	localparam int TA_W = (STOP_MAX > 1) ? $clog2(STOP_MAX) : 1;
	localparam int QN_W = $clog2(SEQ_MAX + 1);
	localparam int QI_W = (SEQ_MAX > 1) ? $clog2(SEQ_MAX) : 1;
	localparam int LW   = $clog2(SEQ_LEN + 1);
	localparam int HA_W = $clog2(SEQ_LEN);
	localparam int MA_W = $clog2(SEQ_MAX * SEQ_LEN);

	typedef enum logic [3:0] {
		T_IDLE = 4'b0001,
		T_EXEC = 4'b0010,
		T_WALK = 4'b0100,
		T_FIN  = 4'b1000
	} top_state_t;

	top_state_t          state_q;
	logic [REQ_W-1:0]    type_q;
	logic [TOKEN_W-1:0]  tok_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [POS_W-1:0]    pos_q;
	logic [LEN_W-1:0]    len_q;
	logic                chk_q;

	logic [MINTOK_W-1:0] min_tok_q;
	logic [COUNT_W-1:0]  eos_count_q;
	logic [COUNT_W-1:0]  stop_count_q;
	logic [COUNT_W-1:0]  seq_count_q;

	logic [MINTOK_W-1:0] min_left_q;
	logic [LW-1:0]       fill_q;
	logic [HA_W-1:0]     wp_q;
	logic [LW-1:0]       seq_len_q [SEQ_MAX];

	logic                out_v_q;
	logic [M_TDATA_W-1:0] out_data_q;

	logic [EN_W-1:0]     eos_n;
	logic [TN_W-1:0]     stop_n;
	logic [QN_W-1:0]     seq_n;
	logic [MINTOK_W-1:0] min_next;
	logic                checked;
	logic                accept;
	logic                exec;
	logic                out_free;
	logic                walk_start;
	logic                walk_done;
	logic                eos_we;
	logic                stop_we;
	logic                seq_we;
	logic                hist_we;
	logic [LW-1:0]       len_sat;
	logic [MA_W-1:0]     seq_waddr;
	logic [QI_W-1:0]     seq_sel;
	logic [LW-1:0]       cur_len;
	logic [EA_W-1:0]     eos_raddr;
	logic [TA_W-1:0]     stop_raddr;
	logic [MA_W-1:0]     seq_raddr;
	logic [HA_W-1:0]     hist_raddr;
	logic [TOKEN_W-1:0]  eos_rd;
	logic [TOKEN_W-1:0]  stop_rd;
	logic [TOKEN_W-1:0]  seq_rd;
	logic [TOKEN_W-1:0]  hist_rd;
	cmp_req_t            cmp_req;
	hit_t                hits;
	logic                res_done;
	logic [REASON_W-1:0] res_reason;
	logic                res_keep;

	assign s_tready = (state_q == T_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign exec     = (state_q == T_EXEC);
	assign out_free = !out_v_q || m_tready;

	// effective table counts saturate at the table sizes
	assign eos_n  = (32'(eos_count_q) > EOS_MAX) ? EN_W'(EOS_MAX) : EN_W'(eos_count_q);
	assign stop_n = (32'(stop_count_q) > STOP_MAX) ? TN_W'(STOP_MAX) : TN_W'(stop_count_q);
	assign seq_n  = (32'(seq_count_q) > SEQ_MAX) ? QN_W'(SEQ_MAX) : QN_W'(seq_count_q);

	assign min_next = (min_left_q != '0) ? min_left_q - MINTOK_W'(1) : min_left_q;
	assign checked  = (min_tok_q == '0) || (min_next == '0);

	assign eos_we  = exec && (type_q == REQ_EOS_SET) && (32'(slot_q) < EOS_MAX);
	assign stop_we = exec && (type_q == REQ_STOP_SET) && (32'(slot_q) < STOP_MAX);
	assign seq_we  = exec && (type_q == REQ_SEQ_ELEM) && (32'(slot_q) < SEQ_MAX)
			&& (32'(pos_q) < SEQ_LEN);
	assign hist_we = exec && (type_q == REQ_TOKEN) && checked && (seq_n != '0);
	assign walk_start = exec && (type_q == REQ_TOKEN) && checked;

	assign seq_waddr = MA_W'(32'(slot_q) * SEQ_LEN + 32'(pos_q));
	assign len_sat   = (32'(len_q) > SEQ_LEN) ? LW'(SEQ_LEN) : LW'(len_q);
	assign cur_len   = seq_len_q[seq_sel];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_tok_q    <= '0;
			eos_count_q  <= '0;
			stop_count_q <= '0;
			seq_count_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_MIN_TOK:    min_tok_q    <= cfg_wdata[MINTOK_W-1:0];
				REG_EOS_COUNT:  eos_count_q  <= cfg_wdata[COUNT_W-1:0];
				REG_STOP_COUNT: stop_count_q <= cfg_wdata[COUNT_W-1:0];
				REG_SEQ_COUNT:  seq_count_q  <= cfg_wdata[COUNT_W-1:0];
				default:        min_tok_q    <= min_tok_q;
			endcase
		end
	end

	// input item register
	always_ff @(posedge clk) begin
		if (accept) begin
			type_q <= s_tuser[REQ_W-1:0];
			tok_q  <= s_tdata[TOKEN_W-1:0];
			slot_q <= s_tdata[TOKEN_W +: SLOT_W];
			pos_q  <= s_tdata[TOKEN_W + SLOT_W +: POS_W];
			len_q  <= s_tdata[TOKEN_W + SLOT_W + POS_W +: LEN_W];
		end
	end

	// sequencer and request state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= T_IDLE;
			chk_q      <= 1'b0;
			min_left_q <= '0;
			fill_q     <= '0;
			wp_q       <= '0;
			for (int i = 0; i < SEQ_MAX; i++) begin
				seq_len_q[i] <= '0;
			end
		end else begin
			case (state_q)
				T_IDLE: begin
					if (accept) begin
						state_q <= T_EXEC;
					end
				end
				T_EXEC: begin
					case (type_q)
						REQ_TOKEN: begin
							min_left_q <= min_next;
							chk_q      <= checked;
							state_q    <= checked ? T_WALK : T_FIN;
							if (hist_we) begin
								wp_q   <= (wp_q == HA_W'(SEQ_LEN - 1)) ? '0 : wp_q + HA_W'(1);
								fill_q <= (fill_q == LW'(SEQ_LEN)) ? fill_q : fill_q + LW'(1);
							end
						end
						REQ_SEQ_LEN: begin
							state_q <= T_FIN;
							chk_q   <= 1'b0;
							if (32'(slot_q) < SEQ_MAX) begin
								seq_len_q[QI_W'(slot_q)] <= len_sat;
							end
						end
						REQ_BEGIN: begin
							state_q    <= T_FIN;
							chk_q      <= 1'b0;
							fill_q     <= '0;
							min_left_q <= min_tok_q;
						end
						default: begin
							state_q <= T_FIN;
							chk_q   <= 1'b0;
						end
					endcase
				end
				T_WALK: begin
					if (walk_done) begin
						state_q <= T_FIN;
					end
				end
				T_FIN: begin
					if (out_free) begin
						state_q <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	// result: eos beats stop beats stop sequence
	always_comb begin
		res_done   = 1'b0;
		res_reason = RSN_NONE;
		res_keep   = 1'b0;
		if (type_q == REQ_TOKEN) begin
			res_keep = 1'b1;
			if (chk_q) begin
				if (hits.eos) begin
					res_done   = 1'b1;
					res_reason = RSN_EOS;
					res_keep   = 1'b0;
				end else if (hits.stop) begin
					res_done   = 1'b1;
					res_reason = RSN_STOP;
				end else if (hits.seq) begin
					res_done   = 1'b1;
					res_reason = RSN_SEQ;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (state_q == T_FIN && out_free) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == T_FIN && out_free) begin
			out_data_q <= {(M_TDATA_W - REASON_W - 2)'(0), res_keep, res_reason, res_done};
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;

	tscd_ram #(.WIDTH(TOKEN_W), .DEPTH(EOS_MAX)) u_eos_ram (
		.clk   (clk),
		.we    (eos_we),
		.waddr (EA_W'(slot_q)),
		.wdata (tok_q),
		.raddr (eos_raddr),
		.rdata (eos_rd)
	);

	tscd_ram #(.WIDTH(TOKEN_W), .DEPTH(STOP_MAX)) u_stop_ram (
		.clk   (clk),
		.we    (stop_we),
		.waddr (TA_W'(slot_q)),
		.wdata (tok_q),
		.raddr (stop_raddr),
		.rdata (stop_rd)
	);

	tscd_ram #(.WIDTH(TOKEN_W), .DEPTH(SEQ_MAX * SEQ_LEN)) u_seq_ram (
		.clk   (clk),
		.we    (seq_we),
		.waddr (seq_waddr),
		.wdata (tok_q),
		.raddr (seq_raddr),
		.rdata (seq_rd)
	);

	tscd_ram #(.WIDTH(TOKEN_W), .DEPTH(SEQ_LEN)) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (wp_q),
		.wdata (tok_q),
		.raddr (hist_raddr),
		.rdata (hist_rd)
	);

	tscd_walk #(
		.EOS_MAX  (EOS_MAX),
		.STOP_MAX (STOP_MAX),
		.SEQ_MAX  (SEQ_MAX),
		.SEQ_LEN  (SEQ_LEN)
	) u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (walk_start),
		.eos_n     (eos_n),
		.stop_n    (stop_n),
		.seq_n     (seq_n),
		.fill      (fill_q),
		.wr_ptr    (wp_q),
		.cur_len   (cur_len),
		.seq_sel   (seq_sel),
		.eos_addr  (eos_raddr),
		.stop_addr (stop_raddr),
		.seq_addr  (seq_raddr),
		.hist_addr (hist_raddr),
		.req       (cmp_req),
		.done      (walk_done)
	);

	tscd_match u_match (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (walk_start),
		.req     (cmp_req),
		.tok     (tok_q),
		.eos_rd  (eos_rd),
		.stop_rd (stop_rd),
		.seq_rd  (seq_rd),
		.hist_rd (hist_rd),
		.hits    (hits)
	);

`ifndef SYNTHESIS
	a_done_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		walk_done |-> state_q == T_WALK)
		else $error("walk finished outside the walk state");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= LW'(SEQ_LEN))
		else $error("history fill beyond its depth");

	a_load_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(state_q == T_FIN))
		else $error("result loaded outside the finish state");

	a_eos_drops: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_data_q[REASON_W:1] == RSN_EOS |-> !out_data_q[REASON_W + 1])
		else $error("eos result marks the token as kept");

	a_walk_no_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_req.valid |-> state_q == T_WALK)
		else $error("table compare issued outside a token walk");
`endif

endmodule

// ===== rtl/tscd_ram.sv =====
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
module tscd_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/tscd_walk.sv =====
// Table walk sequencer: steps through eos entries, stop entries and each
// stored stop sequence against the history, one read per cycle.
// Depends on tscd_pkg.
module tscd_walk #(
	parameter int EOS_MAX  = 8,
	parameter int STOP_MAX = 8,
	parameter int SEQ_MAX  = 8,
	parameter int SEQ_LEN  = 16,
	parameter int EN_W     = $clog2(EOS_MAX + 1),
	parameter int EA_W     = (EOS_MAX > 1) ? $clog2(EOS_MAX) : 1,
	parameter int TN_W     = $clog2(STOP_MAX + 1),
	parameter int TA_W     = (STOP_MAX > 1) ? $clog2(STOP_MAX) : 1,
	parameter int QN_W     = $clog2(SEQ_MAX + 1),
	parameter int QI_W     = (SEQ_MAX > 1) ? $clog2(SEQ_MAX) : 1,
	parameter int LW       = $clog2(SEQ_LEN + 1),
	parameter int HA_W     = $clog2(SEQ_LEN),
	parameter int MA_W     = $clog2(SEQ_MAX * SEQ_LEN)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [EN_W-1:0]     eos_n,
	input  logic [TN_W-1:0]     stop_n,
	input  logic [QN_W-1:0]     seq_n,
	input  logic [LW-1:0]       fill,
	input  logic [HA_W-1:0]     wr_ptr,
	input  logic [LW-1:0]       cur_len,
	output logic [QI_W-1:0]     seq_sel,
	output logic [EA_W-1:0]     eos_addr,
	output logic [TA_W-1:0]     stop_addr,
	output logic [MA_W-1:0]     seq_addr,
	output logic [HA_W-1:0]     hist_addr,
	output tscd_pkg::cmp_req_t  req,
	output logic                done
);
	import tscd_pkg::*;

	typedef enum logic [5:0] {
		W_IDLE  = 6'b000001,
		W_EOS   = 6'b000010,
		W_STOP  = 6'b000100,
		W_SEQL  = 6'b001000,
		W_SEQE  = 6'b010000,
		W_DRAIN = 6'b100000
	} walk_state_t;

	walk_state_t      state_q;
	logic [EN_W-1:0]  ei_q;
	logic [TN_W-1:0]  ti_q;
	logic [QN_W-1:0]  qi_q;
	logic [HA_W-1:0]  el_q;
	logic [HA_W-1:0]  hp_q;
	logic [MA_W-1:0]  base_q;
	logic             first_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_IDLE;
			ei_q    <= '0;
			ti_q    <= '0;
			qi_q    <= '0;
			el_q    <= '0;
			hp_q    <= '0;
			base_q  <= '0;
			first_q <= 1'b0;
		end else begin
			case (state_q)
				W_IDLE: begin
					if (start) begin
						ei_q    <= '0;
						state_q <= W_EOS;
					end
				end
				W_EOS: begin
					if (ei_q == eos_n) begin
						ti_q    <= '0;
						state_q <= W_STOP;
					end else begin
						ei_q <= ei_q + EN_W'(1);
					end
				end
				W_STOP: begin
					if (ti_q == stop_n) begin
						qi_q    <= '0;
						base_q  <= '0;
						state_q <= W_SEQL;
					end else begin
						ti_q <= ti_q + TN_W'(1);
					end
				end
				W_SEQL: begin
					if (qi_q == seq_n) begin
						state_q <= W_DRAIN;
					end else if (cur_len == '0 || cur_len > fill) begin
						// disabled or longer than the history: skip
						qi_q   <= qi_q + QN_W'(1);
						base_q <= base_q + MA_W'(SEQ_LEN);
					end else begin
						// walk backward from the newest token and the last element
						el_q    <= HA_W'(cur_len - LW'(1));
						hp_q    <= (wr_ptr == '0) ? HA_W'(SEQ_LEN - 1) : wr_ptr - HA_W'(1);
						first_q <= 1'b1;
						state_q <= W_SEQE;
					end
				end
				W_SEQE: begin
					first_q <= 1'b0;
					if (el_q == '0) begin
						qi_q    <= qi_q + QN_W'(1);
						base_q  <= base_q + MA_W'(SEQ_LEN);
						state_q <= W_SEQL;
					end else begin
						el_q <= el_q - HA_W'(1);
						hp_q <= (hp_q == '0) ? HA_W'(SEQ_LEN - 1) : hp_q - HA_W'(1);
					end
				end
				W_DRAIN: begin
					state_q <= W_IDLE;
				end
				default: begin
					state_q <= W_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		req       = '0;
		req.kind  = KIND_EOS;
		case (state_q)
			W_EOS: begin
				req.valid = (ei_q != eos_n);
				req.kind  = KIND_EOS;
			end
			W_STOP: begin
				req.valid = (ti_q != stop_n);
				req.kind  = KIND_STOP;
			end
			W_SEQE: begin
				req.valid = 1'b1;
				req.kind  = KIND_SEQ;
				req.first = first_q;
				req.last  = (el_q == '0);
			end
			default: begin
				req.valid = 1'b0;
			end
		endcase
	end

	assign eos_addr  = ei_q[EA_W-1:0];
	assign stop_addr = ti_q[TA_W-1:0];
	assign seq_sel   = qi_q[QI_W-1:0];
	assign seq_addr  = base_q + MA_W'(el_q);
	assign hist_addr = hp_q;
	assign done      = (state_q == W_DRAIN);

endmodule

// ===== rtl/tscd_match.sv =====
// Shared compare unit: one equality compare per cycle on the registered
// RAM read data, accumulating the eos, stop and stop-sequence hits.
// Depends on tscd_pkg.
module tscd_match (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clear,
	input  tscd_pkg::cmp_req_t            req,
	input  logic [tscd_pkg::TOKEN_W-1:0]  tok,
	input  logic [tscd_pkg::TOKEN_W-1:0]  eos_rd,
	input  logic [tscd_pkg::TOKEN_W-1:0]  stop_rd,
	input  logic [tscd_pkg::TOKEN_W-1:0]  seq_rd,
	input  logic [tscd_pkg::TOKEN_W-1:0]  hist_rd,
	output tscd_pkg::hit_t                hits
);
	import tscd_pkg::*;

	cmp_req_t           req_s1;
	hit_t               hits_q;
	logic               run_ok_q;
	logic [TOKEN_W-1:0] opa;
	logic [TOKEN_W-1:0] opb;
	logic               eq;
	logic               run;

	always_comb begin
		opa = tok;
		opb = eos_rd;
		case (req_s1.kind)
			KIND_EOS: begin
				opb = eos_rd;
			end
			KIND_STOP: begin
				opb = stop_rd;
			end
			KIND_SEQ: begin
				opa = hist_rd;
				opb = seq_rd;
			end
			default: begin
				opb = eos_rd;
			end
		endcase
	end

	assign eq  = (opa == opb);
	assign run = req_s1.first ? eq : (run_ok_q & eq);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s1   <= '0;
			hits_q   <= '0;
			run_ok_q <= 1'b0;
		end else begin
			req_s1 <= req;
			if (clear) begin
				hits_q   <= '0;
				run_ok_q <= 1'b0;
			end else if (req_s1.valid) begin
				case (req_s1.kind)
					KIND_EOS: begin
						hits_q.eos <= hits_q.eos | eq;
					end
					KIND_STOP: begin
						hits_q.stop <= hits_q.stop | eq;
					end
					KIND_SEQ: begin
						run_ok_q <= run;
						if (req_s1.last && run) begin
							hits_q.seq <= 1'b1;
						end
					end
					default: begin
						run_ok_q <= run_ok_q;
					end
				endcase
			end
		end
	end

	assign hits = hits_q;

endmodule
